// ----- sv/mse_pkg.sv -----
// shared types, constants and helpers of the matrix square engine
// no dependencies; used by mse_mac, the top level and the testbench
package mse_pkg;

    localparam int MAX_SIZE  = 8;
    localparam int ELEM_W    = 16;
    localparam int SIZE_W    = 4;
    localparam int VAL_W     = 35;
    localparam int OUT_IDX_W = 3;
    localparam int IDX_W     = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int ADDR_W    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE * MAX_SIZE) : 1;
    localparam int LOAD_W    = ADDR_W + 1;
    localparam int CMP_W     = (IDX_W > SIZE_W) ? IDX_W : SIZE_W;
    localparam int PROD_W    = 2 * ELEM_W;
    localparam int SUM_W     = PROD_W + IDX_W + 1;
    localparam int ACC_W     = (SUM_W > VAL_W) ? SUM_W : VAL_W + 1;

    // apb register map
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam logic REG_MATRIX_SIZE = 1'b0;
    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_SIZE);

    // tag that travels with each product through the mac pipeline
    typedef struct packed {
        logic             first;
        logic             dot_end;
        logic             final_elem;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } t_tag;

    // clamp the written size to 1..MAX_SIZE
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] n;
        n = v;
        if (v == '0) begin
            n = SIZE_W'(1);
        end else if (32'(v) > MAX_SIZE) begin
            n = SIZE_W'(MAX_SIZE);
        end
        return n;
    endfunction

endpackage

// ----- sv/mse_mac.sv -----
// shared multiply-accumulate unit: registered product, accumulator, saturation
// and the result output register; depends on mse_pkg
module mse_mac (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_vld,
    input  mse_pkg::t_tag                       i_tag,
    input  logic signed [mse_pkg::ELEM_W-1:0]   i_op_a,
    input  logic signed [mse_pkg::ELEM_W-1:0]   i_op_b,
    output logic                                o_valid,
    output logic signed [mse_pkg::VAL_W-1:0]    o_product_value,
    output logic [mse_pkg::OUT_IDX_W-1:0]       o_row_index,
    output logic [mse_pkg::OUT_IDX_W-1:0]       o_column_index,
    output logic                                o_last
);

    localparam int ACC_W = mse_pkg::ACC_W;
    localparam int VAL_W = mse_pkg::VAL_W;
    localparam logic signed [ACC_W-1:0] VAL_MAX =
        {{(ACC_W - VAL_W + 1){1'b0}}, {(VAL_W - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] VAL_MIN =
        {{(ACC_W - VAL_W + 1){1'b1}}, {(VAL_W - 1){1'b0}}};

    logic                                  r_prod_vld;
    mse_pkg::t_tag                         r_prod_tag;
    logic signed [mse_pkg::PROD_W-1:0]     r_prod;
    logic signed [ACC_W-1:0]               r_acc;
    logic signed [ACC_W-1:0]               n_acc;
    logic signed [ACC_W-1:0]               prod_ext;
    logic signed [VAL_W-1:0]               sat_val;

    assign prod_ext = ACC_W'(r_prod);
    assign n_acc    = r_prod_tag.first ? prod_ext : r_acc + prod_ext;

    always_comb begin
        if (n_acc > VAL_MAX) begin
            sat_val = VAL_MAX[VAL_W-1:0];
        end else if (n_acc < VAL_MIN) begin
            sat_val = VAL_MIN[VAL_W-1:0];
        end else begin
            sat_val = n_acc[VAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
            o_valid    <= 1'b0;
        end else begin
            r_prod_vld <= i_vld;
            o_valid    <= r_prod_vld && r_prod_tag.dot_end;
        end
        r_prod     <= i_op_a * i_op_b;
        r_prod_tag <= i_tag;
        if (r_prod_vld) begin
            r_acc <= n_acc;
        end
        if (r_prod_vld && r_prod_tag.dot_end) begin
            o_product_value <= sat_val;
            o_row_index     <= mse_pkg::OUT_IDX_W'(r_prod_tag.row);
            o_column_index  <= mse_pkg::OUT_IDX_W'(r_prod_tag.col);
            o_last          <= r_prod_tag.final_elem;
        end
    end

endmodule

// ----- sv/matrix_square_engine_unit.sv -----
// matrix square engine top level: element store, load and issue sequencer, apb
// register; depends on mse_pkg and mse_mac
//
// Loads an n x n matrix of signed Q8.8 elements, one per start transaction in
// row-major order (n from the matrix_size register, 0 read as 1, above 8 read
// as 8). Loading takes one cycle per element with busy low. After the last
// element busy rises and one shared multiply-accumulate forms each element of
// the square as an n-step dot product, one product per cycle, through the read
// registers, the product register and the output register; busy falls again
// after the final result. Results appear in row-major order, one per strobe on
// o_valid for a single cycle each; the receiver cannot stall them. Writing
// matrix_size drops a partly loaded matrix.
module matrix_square_engine_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [mse_pkg::ELEM_W-1:0]    i_element,
    output logic                                 o_valid,
    output logic signed [mse_pkg::VAL_W-1:0]     o_product_value,
    output logic [mse_pkg::OUT_IDX_W-1:0]        o_row_index,
    output logic [mse_pkg::OUT_IDX_W-1:0]        o_column_index,
    output logic                                 o_last,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [mse_pkg::PADDR_W-1:0]          paddr,
    input  logic [mse_pkg::PDATA_W-1:0]          pwdata,
    output logic [mse_pkg::PDATA_W-1:0]          prdata,
    output logic                                 pready
);

    localparam int IDX_W  = mse_pkg::IDX_W;
    localparam int ADDR_W = mse_pkg::ADDR_W;
    localparam int LOAD_W = mse_pkg::LOAD_W;
    localparam int CMP_W  = mse_pkg::CMP_W;
    localparam int SIZE_W = mse_pkg::SIZE_W;

    typedef enum logic [2:0] {
        S_LOAD  = 3'b001,
        S_ISSUE = 3'b010,
        S_DRAIN = 3'b100
    } t_state;

    t_state                              r_state;
    t_state                              n_state;
    logic [SIZE_W-1:0]                   r_size;
    logic [LOAD_W-1:0]                   r_load;
    logic [IDX_W-1:0]                    r_row;
    logic [IDX_W-1:0]                    r_col;
    logic [IDX_W-1:0]                    r_dot;
    logic signed [mse_pkg::ELEM_W-1:0]   r_mem [mse_pkg::MAX_SIZE * mse_pkg::MAX_SIZE];
    logic signed [mse_pkg::ELEM_W-1:0]   r_rd_a;
    logic signed [mse_pkg::ELEM_W-1:0]   r_rd_b;
    logic                                r_rd_vld;
    mse_pkg::t_tag                       r_rd_tag;
    mse_pkg::t_tag                       issue_tag;

    logic [SIZE_W-1:0]  size_n;
    logic [SIZE_W-1:0]  size_m1;
    logic [LOAD_W-1:0]  total;
    logic               accept;
    logic               cfg_wr;
    logic               issuing;
    logic               row_end;
    logic               col_end;
    logic               dot_end;
    logic [ADDR_W-1:0]  addr_a;
    logic [ADDR_W-1:0]  addr_b;

    assign size_n  = mse_pkg::eff_size(r_size);
    assign size_m1 = size_n - SIZE_W'(1);
    assign total   = LOAD_W'(LOAD_W'(size_n) * LOAD_W'(size_n));

    assign busy    = (r_state != S_LOAD);
    assign accept  = start && !busy;
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready
                     && (paddr[mse_pkg::PADDR_W-1] == mse_pkg::REG_MATRIX_SIZE);
    assign prdata  = (paddr[mse_pkg::PADDR_W-1] == mse_pkg::REG_MATRIX_SIZE)
                     ? mse_pkg::PDATA_W'(r_size) : '0;

    assign issuing = (r_state == S_ISSUE);
    assign dot_end = (CMP_W'(r_dot) == CMP_W'(size_m1));
    assign col_end = (CMP_W'(r_col) == CMP_W'(size_m1));
    assign row_end = (CMP_W'(r_row) == CMP_W'(size_m1));

    // row operand at r*n+i, column operand at i*n+c
    assign addr_a = ADDR_W'(ADDR_W'(r_row) * ADDR_W'(size_n) + ADDR_W'(r_dot));
    assign addr_b = ADDR_W'(ADDR_W'(r_dot) * ADDR_W'(size_n) + ADDR_W'(r_col));

    always_comb begin
        issue_tag.first      = (r_dot == '0);
        issue_tag.dot_end    = dot_end;
        issue_tag.final_elem = dot_end && col_end && row_end;
        issue_tag.row        = r_row;
        issue_tag.col        = r_col;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: begin
                if (accept && (r_load + LOAD_W'(1) == total)) begin
                    n_state = S_ISSUE;
                end
            end
            S_ISSUE: begin
                if (dot_end && col_end && row_end) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (o_valid && o_last) begin
                    n_state = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_size   <= mse_pkg::SIZE_RESET;
            r_load   <= '0;
            r_row    <= '0;
            r_col    <= '0;
            r_dot    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= issuing;
            if (cfg_wr) begin
                r_size <= pwdata[SIZE_W-1:0];
                r_load <= '0;
            end else if (accept) begin
                if (r_load + LOAD_W'(1) == total) begin
                    r_load <= '0;
                end else begin
                    r_load <= r_load + LOAD_W'(1);
                end
            end
            if (issuing) begin
                r_dot <= dot_end ? '0 : r_dot + IDX_W'(1);
                if (dot_end) begin
                    r_col <= col_end ? '0 : r_col + IDX_W'(1);
                    if (col_end) begin
                        r_row <= row_end ? '0 : r_row + IDX_W'(1);
                    end
                end
            end
        end
    end

    // element store: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mem[r_load[ADDR_W-1:0]] <= i_element;
        end
        r_rd_a   <= r_mem[addr_a];
        r_rd_b   <= r_mem[addr_b];
        r_rd_tag <= issue_tag;
    end

    mse_mac u_mac (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_vld           (r_rd_vld),
        .i_tag           (r_rd_tag),
        .i_op_a          (r_rd_a),
        .i_op_b          (r_rd_b),
        .o_valid         (o_valid),
        .o_product_value (o_product_value),
        .o_row_index     (o_row_index),
        .o_column_index  (o_column_index),
        .o_last          (o_last)
    );

endmodule

// ----- sv/mse_checker.sv -----
// port-level checks on the matrix square engine, bound to the top level
// needs only the top level's handshake and strobe ports
module mse_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    input  logic                           busy,
    input  logic                           o_valid,
    input  logic                           o_last
);

    // results only come while a matrix is being worked on
    a_no_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> !o_valid)
        else $error("result strobe while not busy");

    // the final result ends the busy period
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |=> !busy && !o_valid)
        else $error("busy or strobe after final result");

    // work only starts on an accepted transaction
    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a start");

    // strobes never come back to back within a matrix of size above one
    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |=> !o_valid)
        else $error("back-to-back result strobes");

endmodule

bind matrix_square_engine_unit mse_checker u_mse_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_valid     (o_valid),
    .o_last      (o_last)
);

// ----- test/matrix_square_engine_unit_test.sv -----
// self-checking testbench for matrix_square_engine_unit: random and directed matrices,
// squared by an in-bench predictor and compared element by element
// depends on mse_pkg and matrix_square_engine_unit
module matrix_square_engine_unit_test;
    import mse_pkg::*;

    localparam logic [PADDR_W-1:0] SIZE_ADDR   = PADDR_W'(4 * int'(REG_MATRIX_SIZE));
    localparam logic [PADDR_W-1:0] UNUSED_ADDR = PADDR_W'(SIZE_ADDR + 4);
    localparam longint SQUARE_MAX = (64'sd1 <<< (VAL_W - 1)) - 1;
    localparam longint SQUARE_MIN = -SQUARE_MAX - 1;
    localparam int RANDOM_ITEMS  = 470;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic signed [VAL_W-1:0]   value;
        logic [OUT_IDX_W-1:0]      row;
        logic [OUT_IDX_W-1:0]      col;
        logic                      last;
    } square_elem_t;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic signed [ELEM_W-1:0] i_element = '0;
    logic                     o_valid;
    logic signed [VAL_W-1:0]  o_product_value;
    logic [OUT_IDX_W-1:0]     o_row_index;
    logic [OUT_IDX_W-1:0]     o_column_index;
    logic                     o_last;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [PADDR_W-1:0]       paddr = '0;
    logic [PDATA_W-1:0]       pwdata = '0;
    logic [PDATA_W-1:0]       prdata;
    logic                     pready;

    // predictor state
    logic signed [ELEM_W-1:0] loaded_elems [MAX_SIZE*MAX_SIZE];
    int unsigned              elems_loaded = 0;
    logic [SIZE_W-1:0]        size_setting = SIZE_RESET;
    square_elem_t             awaited_squares [$];

    logic signed [ELEM_W-1:0] element_feed [$];
    int unsigned              items_sent = 0;
    int unsigned              mismatches = 0;
    int                       burst_left = 0;
    int                       gap_left = 0;

    matrix_square_engine_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_element       (i_element),
        .o_valid         (o_valid),
        .o_product_value (o_product_value),
        .o_row_index     (o_row_index),
        .o_column_index  (o_column_index),
        .o_last          (o_last),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #10 i_clk = ~i_clk;

    // zero reads as one, anything above the maximum reads as the maximum
    function automatic int unsigned side_length(input logic [SIZE_W-1:0] code);
        if (code == '0) begin
            return 1;
        end else if (int'(code) > MAX_SIZE) begin
            return MAX_SIZE;
        end
        return int'(code);
    endfunction

    // store one element; on the last one of the matrix, queue the whole square
    function automatic void absorb_element(input logic signed [ELEM_W-1:0] e);
        int unsigned n, total, r, c, i, k;
        longint acc;
        square_elem_t s;
        n = side_length(size_setting);
        total = n * n;
        if (elems_loaded >= total) elems_loaded = 0;
        loaded_elems[elems_loaded] = e;
        elems_loaded++;
        if (elems_loaded < total) return;
        elems_loaded = 0;
        k = 0;
        for (r = 0; r < n; r++) begin
            for (c = 0; c < n; c++) begin
                acc = 0;
                for (i = 0; i < n; i++) begin
                    acc += longint'(loaded_elems[r*n+i]) * longint'(loaded_elems[i*n+c]);
                end
                if (acc > SQUARE_MAX) acc = SQUARE_MAX;
                if (acc < SQUARE_MIN) acc = SQUARE_MIN;
                s.value = acc[VAL_W-1:0];
                s.row   = OUT_IDX_W'(r);
                s.col   = OUT_IDX_W'(c);
                s.last  = (k + 1 == total);
                awaited_squares.push_back(s);
                k++;
            end
        end
    endfunction

    // element driver: bursts of transactions with random gaps between them
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!(start && busy)) begin
            if (start) begin
                absorb_element(i_element);
                void'(element_feed.pop_front());
            end
            if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (element_feed.size() > 0) begin
                start <= 1'b1;
                i_element <= element_feed[0];
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        square_elem_t want;
        if (i_rst_n && o_valid) begin
            if (awaited_squares.size() == 0) begin
                $error("result with nothing expected: product_value %0d row %0d col %0d",
                       o_product_value, o_row_index, o_column_index);
                mismatches++;
            end else begin
                want = awaited_squares.pop_front();
                if (o_product_value !== want.value) begin
                    $error("product_value: expected %0d, got %0d", want.value, o_product_value);
                    mismatches++;
                end
                if (o_row_index !== want.row) begin
                    $error("row_index: expected %0d, got %0d", want.row, o_row_index);
                    mismatches++;
                end
                if (o_column_index !== want.col) begin
                    $error("column_index: expected %0d, got %0d", want.col, o_column_index);
                    mismatches++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_last);
                    mismatches++;
                end
            end
        end
    end

    function automatic void queue_matrix(input int unsigned count, input bit extreme);
        logic [ELEM_W-1:0] e;
        int unsigned k;
        for (k = 0; k < count; k++) begin
            if (extreme) begin
                case ($urandom_range(0, 4))
                    0: e = 16'h8000;
                    1: e = 16'h7fff;
                    2: e = 16'h0000;
                    3: e = 16'hffff;
                    default: e = 16'h0001;
                endcase
            end else if ($urandom_range(0, 3) == 0) begin
                e = ELEM_W'($urandom_range(0, 511)) - 16'd256;
            end else begin
                e = ELEM_W'($urandom());
            end
            element_feed.push_back(e);
            items_sent++;
        end
    endfunction

    // wait until every element is in and every square element is out, then let the
    // pipeline drain
    task automatic settle();
        do @(posedge i_clk);
        while (element_feed.size() != 0 || start || awaited_squares.size() != 0 || busy);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == SIZE_ADDR) begin
            size_setting = data[SIZE_W-1:0];
            elems_loaded = 0;
        end
    endtask

    initial begin
        logic [SIZE_W-1:0] code;
        logic [PDATA_W-SIZE_W-1:0] upper;
        int unsigned n, mats, m, phase, pick;
        foreach (loaded_elems[j]) loaded_elems[j] = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // partial load at the reset size, dropped by the size write
        queue_matrix(3, 0);
        settle();
        apb_write(SIZE_ADDR, 32'd1);
        element_feed.push_back(16'sh8000);
        element_feed.push_back(16'sh7fff);
        element_feed.push_back(16'sh0001);
        element_feed.push_back(16'shffff);
        element_feed.push_back(16'sh0000);
        settle();
        // size zero with junk in the upper bits, then a write to an unmapped address
        apb_write(SIZE_ADDR, 32'hffff_fff0);
        element_feed.push_back(16'sh8000);
        settle();
        apb_write(UNUSED_ADDR, 32'd3);
        element_feed.push_back(16'sh7fff);
        settle();
        apb_write(SIZE_ADDR, 32'd2);
        repeat (4) element_feed.push_back(16'sh8000);
        settle();
        apb_write(SIZE_ADDR, 32'd3);
        queue_matrix(2, 1);
        settle();
        apb_write(SIZE_ADDR, 32'd3);
        repeat (4) element_feed.push_back(16'sh7fff);
        repeat (5) element_feed.push_back(16'sh8000);
        settle();

        items_sent = 0;
        phase = 0;
        while (items_sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 15);
            if (phase == 0) code = 4'd15;
            else if (phase == 1) code = 4'd8;
            else if (pick < 11) code = SIZE_W'($urandom_range(1, 4));
            else if (pick == 11) code = '0;
            else if (pick < 14) code = SIZE_W'($urandom_range(5, 7));
            else if (pick == 14) code = SIZE_W'($urandom_range(8, 15));
            else code = SIZE_W'($urandom_range(1, 3));
            upper = $urandom_range(0, 1) ? (PDATA_W-SIZE_W)'($urandom()) : '0;
            apb_write(SIZE_ADDR, {upper, code});
            n = side_length(code);
            mats = (n >= 5) ? 1 : $urandom_range(1, 3);
            for (m = 0; m < mats; m++) queue_matrix(n * n, $urandom_range(0, 5) == 0);
            // leave a part-loaded matrix for the next size write to discard
            if (n > 1 && $urandom_range(0, 3) == 0) queue_matrix($urandom_range(1, n * n - 1), 0);
            settle();
            phase++;
        end

        if (mismatches == 0) begin
            $display("** matrix_square_engine_unit: PASSED **");
        end else begin
            $display("** matrix_square_engine_unit: FAILED **");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("** matrix_square_engine_unit: FAILED **");
        $finish;
    end

endmodule
